### rtl/core/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types, screen geometry and key codes for the text console cursor
// engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

    localparam int LINE_WIDTH  = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int TAB_STEP    = 4;

    localparam int CELL_COUNT  = SCREEN_ROWS * LINE_WIDTH;
    localparam int ADDR_W      = $clog2(CELL_COUNT);

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;

    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [COL_W-1:0]  t_col;
    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [ADDR_W-1:0] t_addr;

    localparam t_char CH_NONE      = 8'd0;
    localparam t_char CH_BACKSPACE = 8'd8;
    localparam t_char CH_TAB       = 8'd9;
    localparam t_char CH_NEWLINE   = 8'd10;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_RDATA,
        S_SCAN,
        S_ZERO,
        S_DONE
    } t_state;

    function automatic t_addr cell_addr(t_row row, t_col col);
        t_addr result;
        result = t_addr'(row) * t_addr'(LINE_WIDTH) + t_addr'(col);
        return result;
    endfunction

endpackage

`default_nettype wire

### rtl/core/tcce_ram.sv
// ----------------------------------------------------------------------------
// tcce_ram
// Single-port synchronous RAM with a registered read, one access per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/text_console_cursor_engine.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Text-mode character store with a cursor: typed characters edit the store
// and move the cursor, read transactions return one cell.
//
//   channel  direction  handshake           payload
//   input    in         i_valid / o_ready   i_kind, i_key_char, i_read_row,
//                                           i_read_col
//   output   out        o_valid / i_ready   o_cursor_*, o_placed_*,
//                                           o_row_overflow, o_read_char
//
// After reset a clearing pass zeroes the store, one cell per cycle
// (CELL_COUNT = 2000 cells); o_ready stays low until it ends.
// One transaction at a time: o_valid rises after EXEC and DONE; a printable
// character also passes ZERO, an in-range cell read RDATA (second RAM
// access); a line-start backspace stays in SCAN per cell scanned, up to
// LINE_WIDTH. A waiting result holds back the next result, not its accept.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_engine (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic            i_kind,
    input  wire tcce_pkg::t_char i_key_char,
    input  wire tcce_pkg::t_row  i_read_row,
    input  wire tcce_pkg::t_col  i_read_col,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output tcce_pkg::t_row       o_cursor_row_out,
    output tcce_pkg::t_col       o_cursor_col_out,
    output logic                 o_placed_valid,
    output tcce_pkg::t_row       o_placed_row,
    output tcce_pkg::t_col       o_placed_col,
    output logic                 o_row_overflow,
    output tcce_pkg::t_char      o_read_char
);

    import tcce_pkg::*;

    t_state r_state, n_state;
    t_addr  r_clr_addr, n_clr_addr;

    logic  r_kind, n_kind;
    t_char r_char, n_char;
    t_row  r_rrow, n_rrow;
    t_col  r_rcol, n_rcol;

    t_row  r_row, n_row;
    t_col  r_col, n_col;

    logic  r_placed, n_placed;
    t_row  r_prow, n_prow;
    t_col  r_pcol, n_pcol;
    logic  r_ovf, n_ovf;
    t_char r_rd, n_rd;

    logic  r_out_valid, n_out_valid;
    t_row  r_o_row, n_o_row;
    t_col  r_o_col, n_o_col;
    logic  r_o_placed, n_o_placed;
    t_row  r_o_prow, n_o_prow;
    t_col  r_o_pcol, n_o_pcol;
    logic  r_o_ovf, n_o_ovf;
    t_char r_o_rd, n_o_rd;

    logic  ram_en;
    logic  ram_we;
    t_addr ram_addr;
    t_char ram_wdata;
    t_char ram_rdata;

    logic [ROW_W:0] row_inc;
    logic           row_last;
    t_row           row_next;
    logic [COL_W:0] col_inc;
    logic [COL_W:0] col_tab;
    logic           read_in_range;
    logic           scan_more;

    tcce_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(CELL_COUNT)
    ) u_store (
        .i_clk  (i_clk),
        .i_en   (ram_en),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    assign row_inc  = {1'b0, r_row} + (ROW_W+1)'(1);
    assign row_last = row_inc >= (ROW_W+1)'(SCREEN_ROWS);
    assign row_next = row_last ? ROW_W'(SCREEN_ROWS - 1) : row_inc[ROW_W-1:0];
    assign col_inc  = {1'b0, r_col} + (COL_W+1)'(1);
    assign col_tab  = {1'b0, r_col} + (COL_W+1)'(TAB_STEP);

    assign read_in_range = ({1'b0, r_rrow} < (ROW_W+1)'(SCREEN_ROWS)) &&
                           ({1'b0, r_rcol} < (COL_W+1)'(LINE_WIDTH));
    assign scan_more     = (r_col != '0) && (ram_rdata == CH_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_row       <= n_row;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_char     <= n_char;
        r_rrow     <= n_rrow;
        r_rcol     <= n_rcol;
        r_placed   <= n_placed;
        r_prow     <= n_prow;
        r_pcol     <= n_pcol;
        r_ovf      <= n_ovf;
        r_rd       <= n_rd;
        r_o_row    <= n_o_row;
        r_o_col    <= n_o_col;
        r_o_placed <= n_o_placed;
        r_o_prow   <= n_o_prow;
        r_o_pcol   <= n_o_pcol;
        r_o_ovf    <= n_o_ovf;
        r_o_rd     <= n_o_rd;
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_kind      = r_kind;
        n_char      = r_char;
        n_rrow      = r_rrow;
        n_rcol      = r_rcol;
        n_row       = r_row;
        n_col       = r_col;
        n_placed    = r_placed;
        n_prow      = r_prow;
        n_pcol      = r_pcol;
        n_ovf       = r_ovf;
        n_rd        = r_rd;
        n_out_valid = r_out_valid && !i_ready;
        n_o_row     = r_o_row;
        n_o_col     = r_o_col;
        n_o_placed  = r_o_placed;
        n_o_prow    = r_o_prow;
        n_o_pcol    = r_o_pcol;
        n_o_ovf     = r_o_ovf;
        n_o_rd      = r_o_rd;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = cell_addr(r_row, r_col);
        ram_wdata   = CH_NONE;
        o_ready     = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                ram_en     = 1'b1;
                ram_we     = 1'b1;
                ram_addr   = r_clr_addr;
                n_clr_addr = r_clr_addr + t_addr'(1);
                if (r_clr_addr == t_addr'(CELL_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_kind  = i_kind;
                    n_char  = i_key_char;
                    n_rrow  = i_read_row;
                    n_rcol  = i_read_col;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_placed = 1'b0;
                n_prow   = '0;
                n_pcol   = '0;
                n_ovf    = 1'b0;
                n_rd     = CH_NONE;
                n_state  = S_DONE;
                if (r_kind == KIND_READ) begin
                    if (read_in_range) begin
                        ram_en   = 1'b1;
                        ram_addr = cell_addr(r_rrow, r_rcol);
                        n_state  = S_RDATA;
                    end
                end else begin
                    unique case (r_char)
                        CH_NONE: begin
                        end
                        CH_NEWLINE: begin
                            n_row    = row_next;
                            n_col    = '0;
                            n_ovf    = row_last;
                            ram_en   = 1'b1;
                            ram_we   = 1'b1;
                            ram_addr = cell_addr(n_row, n_col);
                        end
                        CH_TAB: begin
                            if (col_tab >= (COL_W+1)'(LINE_WIDTH)) begin
                                n_row = row_next;
                                n_col = '0;
                                n_ovf = row_last;
                            end else begin
                                n_col = col_tab[COL_W-1:0];
                            end
                            ram_en   = 1'b1;
                            ram_we   = 1'b1;
                            ram_addr = cell_addr(n_row, n_col);
                        end
                        CH_BACKSPACE: begin
                            if (r_col != '0) begin
                                n_col    = r_col - t_col'(1);
                                ram_en   = 1'b1;
                                ram_we   = 1'b1;
                                ram_addr = cell_addr(r_row, n_col);
                            end else if (r_row != '0) begin
                                n_row    = r_row - t_row'(1);
                                n_col    = t_col'(LINE_WIDTH - 1);
                                ram_en   = 1'b1;
                                ram_addr = cell_addr(n_row, n_col);
                                n_state  = S_SCAN;
                            end
                        end
                        default: begin
                            ram_en    = 1'b1;
                            ram_we    = 1'b1;
                            ram_wdata = r_char;
                            n_placed  = 1'b1;
                            n_prow    = r_row;
                            n_pcol    = r_col;
                            if (col_inc >= (COL_W+1)'(LINE_WIDTH)) begin
                                n_row = row_next;
                                n_col = '0;
                                n_ovf = row_last;
                            end else begin
                                n_col = col_inc[COL_W-1:0];
                            end
                            n_state = S_ZERO;
                        end
                    endcase
                end
            end

            S_RDATA: begin
                n_rd    = ram_rdata;
                n_state = S_DONE;
            end

            // read data belongs to the cell at the cursor; next cell is
            // fetched speculatively, or the cursor cell is cleared on stop
            S_SCAN: begin
                ram_en = 1'b1;
                if (scan_more) begin
                    n_col    = r_col - t_col'(1);
                    ram_addr = cell_addr(r_row, n_col);
                end else begin
                    ram_we  = 1'b1;
                    n_state = S_DONE;
                end
            end

            S_ZERO: begin
                ram_en  = 1'b1;
                ram_we  = 1'b1;
                n_state = S_DONE;
            end

            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_o_row     = r_row;
                    n_o_col     = r_col;
                    n_o_placed  = r_placed;
                    n_o_prow    = r_prow;
                    n_o_pcol    = r_pcol;
                    n_o_ovf     = r_ovf;
                    n_o_rd      = r_rd;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid          = r_out_valid;
    assign o_cursor_row_out = r_o_row;
    assign o_cursor_col_out = r_o_col;
    assign o_placed_valid   = r_o_placed;
    assign o_placed_row     = r_o_prow;
    assign o_placed_col     = r_o_pcol;
    assign o_row_overflow   = r_o_ovf;
    assign o_read_char      = r_o_rd;

endmodule

`default_nettype wire

### tb/tb_text_console_cursor_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_console_cursor_engine
// Self-checking bench for the text console cursor engine. A directed table
// covers reset, field extremes, control keys, the backspace line-start scan
// and out-of-range reads. Weighted random traffic then drives the cursor to
// the last row and back. Each result is predicted by a shadow screen and
// cursor or given by a typed table row; input is bursty, output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_text_console_cursor_engine;
    import tcce_pkg::*;

    localparam int MAX_CYCLES     = 1_000_000;
    localparam int RANDOM_ITEMS   = 1750;
    localparam int DRAIN_CYCLES   = 120;
    localparam int MAX_REPORTS    = 10;
    localparam int DIRECTED_COUNT = 25;

    typedef struct packed {
        logic  kind;
        t_char key;
        t_row  rrow;
        t_col  rcol;
    } t_key_txn;

    typedef struct packed {
        t_row  cur_row;
        t_col  cur_col;
        logic  placed;
        t_row  placed_row;
        t_col  placed_col;
        logic  overflow;
        t_char rd;
    } t_screen_result;

    typedef struct packed {
        t_key_txn       txn;
        logic           typed;
        t_screen_result result;
    } t_directed_row;

    typedef enum int {MIX_TYPING, MIX_EDITING, MIX_BALANCED} t_key_mix;
    typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_CHOKED} t_rx_mode;

    localparam t_screen_result NOT_TYPED = '0;
    localparam t_screen_result AT_ORIGIN = '0;

    localparam t_directed_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{'{KIND_READ, CH_NONE, 5'd0, 7'd0}, 1'b1, AT_ORIGIN},
        '{'{KIND_CHAR, CH_NONE, 5'd3, 7'd9}, 1'b1, AT_ORIGIN},
        '{'{KIND_CHAR, CH_BACKSPACE, 5'd0, 7'd0}, 1'b1, AT_ORIGIN},
        '{'{KIND_READ, 8'hFF, 5'd31, 7'd127}, 1'b1, AT_ORIGIN},
        '{'{KIND_CHAR, 8'h41, 5'd0, 7'd0}, 1'b1,
          '{5'd0, 7'd1, 1'b1, 5'd0, 7'd0, 1'b0, 8'h00}},
        '{'{KIND_READ, CH_NONE, 5'd0, 7'd0}, 1'b1,
          '{5'd0, 7'd1, 1'b0, 5'd0, 7'd0, 1'b0, 8'h41}},
        '{'{KIND_CHAR, 8'hFF, 5'd31, 7'd127}, 1'b1,
          '{5'd0, 7'd2, 1'b1, 5'd0, 7'd1, 1'b0, 8'h00}},
        '{'{KIND_CHAR, CH_TAB, 5'd0, 7'd0}, 1'b1,
          '{5'd0, 7'd6, 1'b0, 5'd0, 7'd0, 1'b0, 8'h00}},
        '{'{KIND_CHAR, CH_BACKSPACE, 5'd0, 7'd0}, 1'b1,
          '{5'd0, 7'd5, 1'b0, 5'd0, 7'd0, 1'b0, 8'h00}},
        '{'{KIND_CHAR, CH_NEWLINE, 5'd0, 7'd0}, 1'b1,
          '{5'd1, 7'd0, 1'b0, 5'd0, 7'd0, 1'b0, 8'h00}},
        // line-start backspace scans back to the last filled cell
        '{'{KIND_CHAR, CH_BACKSPACE, 5'd0, 7'd0}, 1'b0, NOT_TYPED},
        '{'{KIND_READ, CH_NONE, 5'd0, 7'd1}, 1'b0, NOT_TYPED},
        '{'{KIND_CHAR, 8'h01, 5'd0, 7'd0}, 1'b0, NOT_TYPED},
        '{'{KIND_CHAR, 8'h07, 5'd0, 7'd0}, 1'b0, NOT_TYPED},
        '{'{KIND_CHAR, 8'h0B, 5'd0, 7'd0}, 1'b0, NOT_TYPED},
        '{'{KIND_CHAR, 8'h7F, 5'd0, 7'd0}, 1'b0, NOT_TYPED},
        '{'{KIND_CHAR, 8'h80, 5'd0, 7'd0}, 1'b0, NOT_TYPED},
        '{'{KIND_READ, CH_NONE, 5'd24, 7'd79}, 1'b0, NOT_TYPED},
        '{'{KIND_READ, CH_NONE, 5'd25, 7'd0}, 1'b0, NOT_TYPED},
        '{'{KIND_READ, CH_NONE, 5'd0, 7'd80}, 1'b0, NOT_TYPED},
        '{'{KIND_CHAR, CH_NEWLINE, 5'd0, 7'd0}, 1'b0, NOT_TYPED},
        '{'{KIND_CHAR, CH_NEWLINE, 5'd0, 7'd0}, 1'b0, NOT_TYPED},
        // empty row above: scan runs down to column zero
        '{'{KIND_CHAR, CH_BACKSPACE, 5'd0, 7'd0}, 1'b0, NOT_TYPED},
        '{'{KIND_CHAR, CH_BACKSPACE, 5'd0, 7'd0}, 1'b0, NOT_TYPED},
        '{'{KIND_CHAR, CH_TAB, 5'd0, 7'd0}, 1'b0, NOT_TYPED}
    };

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_ready;
    logic  i_kind;
    t_char i_key_char;
    t_row  i_read_row;
    t_col  i_read_col;
    logic  o_valid;
    logic  i_ready;
    t_row  o_cursor_row_out;
    t_col  o_cursor_col_out;
    logic  o_placed_valid;
    t_row  o_placed_row;
    t_col  o_placed_col;
    logic  o_row_overflow;
    t_char o_read_char;

    text_console_cursor_engine u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_kind           (i_kind),
        .i_key_char       (i_key_char),
        .i_read_row       (i_read_row),
        .i_read_col       (i_read_col),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_cursor_row_out (o_cursor_row_out),
        .o_cursor_col_out (o_cursor_col_out),
        .o_placed_valid   (o_placed_valid),
        .o_placed_row     (o_placed_row),
        .o_placed_col     (o_placed_col),
        .o_row_overflow   (o_row_overflow),
        .o_read_char      (o_read_char)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the screen and cursor
    t_char shadow_screen [SCREEN_ROWS][LINE_WIDTH];
    t_row  shadow_row;
    t_col  shadow_col;

    t_screen_result pending_results [$];
    t_screen_result got_result;
    t_screen_result want_result;
    int             mismatches  = 0;
    int             cycle_count = 0;
    int             burst_left  = 0;

    function automatic logic advance_row();
        shadow_col = '0;
        if (int'(shadow_row) + 1 >= SCREEN_ROWS) begin
            shadow_row = t_row'(SCREEN_ROWS - 1);
            return 1'b1;
        end
        shadow_row = shadow_row + t_row'(1);
        return 1'b0;
    endfunction

    function automatic t_screen_result apply_keystroke(t_key_txn t);
        t_screen_result r;
        r = '0;
        if (t.kind == KIND_READ) begin
            if (int'(t.rrow) < SCREEN_ROWS && int'(t.rcol) < LINE_WIDTH) begin
                r.rd = shadow_screen[t.rrow][t.rcol];
            end
        end else begin
            case (t.key)
                CH_NONE: ;
                CH_NEWLINE: begin
                    r.overflow = advance_row();
                    shadow_screen[shadow_row][shadow_col] = CH_NONE;
                end
                CH_TAB: begin
                    shadow_col = shadow_col + t_col'(TAB_STEP);
                    if (int'(shadow_col) >= LINE_WIDTH) r.overflow = advance_row();
                    shadow_screen[shadow_row][shadow_col] = CH_NONE;
                end
                CH_BACKSPACE: begin
                    if (shadow_row != '0 || shadow_col != '0) begin
                        if (shadow_col != '0) begin
                            shadow_col = shadow_col - t_col'(1);
                        end else begin
                            shadow_row = shadow_row - t_row'(1);
                            shadow_col = t_col'(LINE_WIDTH - 1);
                            while (shadow_col != '0 &&
                                   shadow_screen[shadow_row][shadow_col] == CH_NONE)
                                shadow_col = shadow_col - t_col'(1);
                        end
                        shadow_screen[shadow_row][shadow_col] = CH_NONE;
                    end
                end
                default: begin
                    shadow_screen[shadow_row][shadow_col] = t.key;
                    r.placed     = 1'b1;
                    r.placed_row = shadow_row;
                    r.placed_col = shadow_col;
                    shadow_col   = shadow_col + t_col'(1);
                    if (int'(shadow_col) >= LINE_WIDTH) r.overflow = advance_row();
                    shadow_screen[shadow_row][shadow_col] = CH_NONE;
                end
            endcase
        end
        r.cur_row = shadow_row;
        r.cur_col = shadow_col;
        return r;
    endfunction

    function automatic t_key_txn random_keystroke(t_key_mix mix);
        t_key_txn t;
        int pick;
        int lim_read, lim_zero, lim_nl, lim_tab, lim_bs;
        pick = $urandom_range(0, 99);
        case (mix)
            MIX_TYPING: begin
                lim_read = 10; lim_zero = 13; lim_nl = 18; lim_tab = 24; lim_bs = 34;
            end
            MIX_EDITING: begin
                lim_read = 15; lim_zero = 20; lim_nl = 40; lim_tab = 50; lim_bs = 78;
            end
            default: begin
                lim_read = 15; lim_zero = 18; lim_nl = 30; lim_tab = 40; lim_bs = 55;
            end
        endcase
        t.kind = KIND_CHAR;
        t.key  = t_char'($urandom);
        t.rrow = t_row'($urandom);
        t.rcol = t_col'($urandom);
        if (pick < lim_read) begin
            t.kind = KIND_READ;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    // around the cursor, where cells were just written
                    t.rrow = shadow_row;
                    if (shadow_row != '0 && $urandom_range(0, 2) == 0)
                        t.rrow = shadow_row - t_row'(1);
                    t.rcol = t_col'($urandom_range(0, LINE_WIDTH - 1));
                end
                5, 6, 7: begin
                    t.rrow = t_row'($urandom_range(0, SCREEN_ROWS - 1));
                    t.rcol = t_col'($urandom_range(0, LINE_WIDTH - 1));
                end
                default: ;
            endcase
        end else if (pick < lim_zero) begin
            t.key = CH_NONE;
        end else if (pick < lim_nl) begin
            t.key = CH_NEWLINE;
        end else if (pick < lim_tab) begin
            t.key = CH_TAB;
        end else if (pick < lim_bs) begin
            t.key = CH_BACKSPACE;
        end
        return t;
    endfunction

    task automatic hold_off(int n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_keystroke(t_key_txn t, logic typed, t_screen_result typed_result);
        t_screen_result predicted;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                    : $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 15));
        end
        burst_left--;
        @(negedge i_clk);
        i_valid    <= 1'b1;
        i_kind     <= t.kind;
        i_key_char <= t.key;
        i_read_row <= t.rrow;
        i_read_col <= t.rcol;
        do @(posedge i_clk); while (!o_ready);
        predicted = apply_keystroke(t);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    // output side stalls on its own schedule
    initial begin
        t_rx_mode mode;
        int       phase;
        i_ready = 1'b0;
        phase   = 0;
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            repeat ($urandom_range(32, 256)) begin
                @(negedge i_clk);
                phase = (phase + 1) % 5;
                case (mode)
                    RX_OPEN:     i_ready <= 1'b1;
                    RX_COIN:     i_ready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: i_ready <= (phase >= 2);
                    default:     i_ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            got_result = '{o_cursor_row_out, o_cursor_col_out, o_placed_valid, o_placed_row,
                           o_placed_col, o_row_overflow, o_read_char};
            if (pending_results.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected transaction: row %0d col %0d rd %02h",
                             got_result.cur_row, got_result.cur_col, got_result.rd);
                mismatches++;
            end else begin
                want_result = pending_results.pop_front();
                if (got_result !== want_result) begin
                    if (mismatches < MAX_REPORTS)
                        $display("mismatch exp: cur %0d,%0d pl %0b %0d,%0d ovf %0b rd %02h %s",
                                 want_result.cur_row, want_result.cur_col, want_result.placed,
                                 want_result.placed_row, want_result.placed_col,
                                 want_result.overflow, want_result.rd, "");
                    if (mismatches < MAX_REPORTS)
                        $display("         got: cur %0d,%0d pl %0b %0d,%0d ovf %0b rd %02h",
                                 got_result.cur_row, got_result.cur_col, got_result.placed,
                                 got_result.placed_row, got_result.placed_col,
                                 got_result.overflow, got_result.rd);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < MAX_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int       random_sent;
        int       seg;
        int       seg_len;
        t_key_mix mix;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_kind     = KIND_CHAR;
        i_key_char = CH_NONE;
        i_read_row = '0;
        i_read_col = '0;
        foreach (shadow_screen[r, c]) shadow_screen[r][c] = CH_NONE;
        shadow_row = '0;
        shadow_col = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_keystroke(DIRECTED_ROWS[i].txn, DIRECTED_ROWS[i].typed,
                           DIRECTED_ROWS[i].result);
        wait_drained();

        random_sent = 0;
        seg         = 0;
        while (random_sent < RANDOM_ITEMS) begin
            mix     = t_key_mix'(seg % 3);
            seg_len = $urandom_range(150, 350);
            for (int i = 0; i < seg_len && random_sent < RANDOM_ITEMS; i++) begin
                send_keystroke(random_keystroke(mix), 1'b0, NOT_TYPED);
                random_sent++;
            end
            if (seg % 2 == 1) wait_drained();
            seg++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
